>>> hdl/efifo_pkg.sv
// Shared types and constants for the endian byte FIFO.
package efifo_pkg;

	// Width of the reported fill level
	localparam int unsigned FILL_W = 10;

	// Command codes on the input item
	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_e;

	// Operation after classification by the front end
	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_PEEK,
		OP_CLEAR,
		OP_REJECT
	} op_e;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHECK,
		BK_WRITE,
		BK_READ,
		BK_DRAIN,
		BK_DONE
	} bk_state_e;

	// Input item
	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  byte_count;
		logic        little_endian;
		logic [63:0] push_value;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [63:0]       read_value;
		logic              ok;
		logic [FILL_W-1:0] fill_level;
	} out_item_t;

	// Classified job between front and back
	typedef struct packed {
		op_e         op;
		logic [3:0]  cnt;
		logic        le;
		logic [63:0] value;
	} job_t;

endpackage

>>> hdl/endian_byte_fifo_unit.sv
// Top level of the endian byte FIFO: front end, job queue and back end.
// The back end takes one job at a time and moves its bytes one by one through the
// byte-wide store port; clear and refused items skip the byte states.
// New items are still accepted while a job runs, until the job queue is full.
// Two items may wait in the job queue; reset empties it and the FIFO; no result stalls.
module endian_byte_fifo_unit import efifo_pkg::*; #(
	parameter int unsigned CAPACITY = 1023
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  cmd_item,
	output logic      done,
	output out_item_t result
);

	job_t new_job, head;
	logic job_push, queue_full, job_valid, job_pop;

	efifo_front u_front (
		.start      (start),
		.busy       (busy),
		.cmd_item   (cmd_item),
		.queue_full (queue_full),
		.job_push   (job_push),
		.job        (new_job)
	);

	efifo_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (new_job),
		.full      (queue_full),
		.job_valid (job_valid),
		.pop       (job_pop),
		.head      (head)
	);

	efifo_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.head      (head),
		.job_pop   (job_pop),
		.done      (done),
		.result    (result)
	);

endmodule

>>> hdl/efifo_front.sv
// Front end: accepts command items and classifies them into jobs.
module efifo_front import efifo_pkg::*; (
	input  logic     start,
	output logic     busy,
	input  in_item_t cmd_item,
	input  logic     queue_full,
	output logic     job_push,
	output job_t     job
);

	logic cnt_valid;

	// Accept only while the job queue has room
	assign busy     = queue_full;
	assign job_push = start && !queue_full;

	// Byte count must lie in 1..8 for push, pop and peek
	assign cnt_valid = (cmd_item.byte_count != 4'd0) && (cmd_item.byte_count <= 4'd8);

	// Command decode
	always_comb begin
		job.cnt   = cmd_item.byte_count;
		job.le    = cmd_item.little_endian;
		job.value = cmd_item.push_value;
		unique case (cmd_e'(cmd_item.cmd))
			CMD_PUSH:  job.op = cnt_valid ? OP_PUSH : OP_REJECT;
			CMD_POP:   job.op = cnt_valid ? OP_POP : OP_REJECT;
			CMD_PEEK:  job.op = cnt_valid ? OP_PEEK : OP_REJECT;
			CMD_CLEAR: job.op = OP_CLEAR;
			default:   job.op = OP_REJECT;
		endcase
	end

endmodule

>>> hdl/efifo_queue.sv
// Two-entry job queue between front and back ends.
module efifo_queue import efifo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic job_valid,
	input  logic pop,
	output job_t head
);

	localparam int unsigned DEPTH = 2;

	job_t       slot_q [DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'(DEPTH));
	assign job_valid = (count_q != 2'd0);
	assign head      = slot_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> job_valid)
		else $error("job queue read while empty");
`endif

endmodule

>>> hdl/efifo_back.sv
// Back end: byte store, pointers and the byte-at-a-time sequencer.
module efifo_back import efifo_pkg::*; #(
	parameter int unsigned CAPACITY = 1023
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      head,
	output logic      job_pop,
	output logic      done,
	output out_item_t result
);

	localparam int unsigned SLOTS = CAPACITY + 1;
	localparam int unsigned PW    = $clog2(SLOTS);
	localparam int unsigned CW    = PW + 1;

	bk_state_e   state_q, state_d;
	job_t        job_q;
	logic        ok_q;
	logic [2:0]  k_q;
	logic [PW-1:0] wr_ptr_q, rd_ptr_q, walk_q, fill_q;
	logic [63:0] sh_q, acc_q;
	logic [7:0]  mem [SLOTS];
	logic [7:0]  rdata_s1;
	logic        rvalid_s1;
	out_item_t   result_q;
	logic        done_q;

	logic          check_ok, room, avail, last_byte;
	logic          mem_we, rd_issue;
	logic [2:0]    cnt_m1, pad;
	logic [7:0]    wbyte;
	logic [PW-1:0] space, nxt_fill;
	logic [PW+FILL_W-1:0] fill_ext;
	logic [63:0]   rd_aligned;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(CAPACITY)) ? '0 : p + 1'b1;
	endfunction

	assign done   = done_q;
	assign result = result_q;

	// Space and occupancy checks
	assign space     = PW'(CAPACITY) - fill_q;
	assign room      = {1'b0, space} >= CW'(job_q.cnt);
	assign avail     = {1'b0, fill_q} >= CW'(job_q.cnt);
	assign cnt_m1    = 3'(job_q.cnt - 4'd1);
	assign pad       = 3'(4'd8 - job_q.cnt);
	assign last_byte = (k_q == cnt_m1);

	always_comb begin
		case (job_q.op)
			OP_PUSH:  check_ok = room;
			OP_POP:   check_ok = avail;
			OP_PEEK:  check_ok = avail;
			OP_CLEAR: check_ok = 1'b1;
			default:  check_ok = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (job_valid) state_d = BK_CHECK;
			BK_CHECK: begin
				if (check_ok && job_q.op == OP_PUSH) state_d = BK_WRITE;
				else if (check_ok && (job_q.op == OP_POP || job_q.op == OP_PEEK))
					state_d = BK_READ;
				else state_d = BK_DONE;
			end
			BK_WRITE: if (last_byte) state_d = BK_DONE;
			BK_READ:  if (last_byte) state_d = BK_DRAIN;
			BK_DRAIN: state_d = BK_DONE;
			BK_DONE:  state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		job_pop  = 1'b0;
		mem_we   = 1'b0;
		rd_issue = 1'b0;
		unique case (state_q)
			BK_IDLE:  job_pop = job_valid;
			BK_WRITE: mem_we = 1'b1;
			BK_READ:  rd_issue = 1'b1;
			default:  ;
		endcase
	end

	// Byte to store and value alignment
	assign wbyte      = job_q.le ? sh_q[7:0] : sh_q[63:56];
	assign rd_aligned = job_q.le ? (acc_q >> {pad, 3'b000}) : acc_q;

	// Fill level after the job
	always_comb begin
		nxt_fill = fill_q;
		case (job_q.op)
			OP_CLEAR: nxt_fill = '0;
			OP_PUSH:  if (ok_q) nxt_fill = fill_q + PW'(job_q.cnt);
			OP_POP:   if (ok_q) nxt_fill = fill_q - PW'(job_q.cnt);
			default:  nxt_fill = fill_q;
		endcase
	end
	assign fill_ext = {{FILL_W{1'b0}}, nxt_fill};

	// Byte store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= wbyte;
		end
		rdata_s1 <= mem[walk_q];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= head;
		end
		if (state_q == BK_CHECK) begin
			ok_q  <= check_ok;
			k_q   <= 3'd0;
			walk_q <= rd_ptr_q;
			acc_q <= '0;
			sh_q  <= job_q.le ? job_q.value : (job_q.value << {pad, 3'b000});
		end else begin
			if (mem_we || rd_issue) begin
				k_q <= k_q + 3'd1;
			end
			if (mem_we) begin
				sh_q <= job_q.le ? (sh_q >> 8) : (sh_q << 8);
			end
			if (rd_issue) begin
				walk_q <= ptr_inc(walk_q);
			end
			if (rvalid_s1) begin
				acc_q <= job_q.le ? {rdata_s1, acc_q[63:8]} : {acc_q[55:0], rdata_s1};
			end
		end
		if (state_q == BK_DONE) begin
			result_q.read_value <= rd_aligned;
			result_q.ok         <= ok_q;
			result_q.fill_level <= fill_ext[FILL_W-1:0];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			fill_q    <= '0;
			rvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= rd_issue;
			done_q    <= (state_q == BK_DONE);
			if (mem_we) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (state_q == BK_DONE) begin
				fill_q <= nxt_fill;
				if (job_q.op == OP_CLEAR) begin
					wr_ptr_q <= '0;
					rd_ptr_q <= '0;
				end else if (job_q.op == OP_POP && ok_q) begin
					rd_ptr_q <= walk_q;
				end
			end
		end
	end

`ifndef SYNTH
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= PW'(CAPACITY))
		else $error("fill level above capacity");
	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.read_value != 64'd0 |-> result_q.ok)
		else $error("nonzero value on a refused item");
`endif

endmodule

>>> test/endian_byte_fifo_unit_test.sv
// Self-checking testbench for the endian byte FIFO unit: directed, capacity and random tests.
`timescale 1ns / 100ps

module endian_byte_fifo_unit_test;
	import efifo_pkg::*;

	localparam int unsigned CAPACITY   = 1023;
	localparam int unsigned SLOTS      = CAPACITY + 1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 20;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  cmd_item;
	logic      done;
	out_item_t result;

	// Shadow copy of the FIFO contents and pointers
	logic [7:0]  shadow_bytes [SLOTS];
	int unsigned shadow_rd;
	int unsigned shadow_wr;

	out_item_t   pending_results [$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          gaps_enabled;

	endian_byte_fifo_unit #(.CAPACITY(CAPACITY)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd_item (cmd_item),
		.done     (done),
		.result   (result)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("endian_byte_fifo_unit verification failed");
		$finish;
	end

	function automatic int unsigned shadow_fill();
		return (shadow_wr + SLOTS - shadow_rd) % SLOTS;
	endfunction

	// Apply one command to the shadow FIFO and return the result it should give
	function automatic out_item_t fifo_apply(input in_item_t it);
		out_item_t   r;
		int unsigned n;
		int unsigned fill;
		int unsigned p;
		int unsigned sh;
		logic [63:0] v;
		r = '0;
		n = it.byte_count;
		fill = shadow_fill();
		if (it.cmd == CMD_CLEAR) begin
			shadow_rd = 0;
			shadow_wr = 0;
			r.ok = 1'b1;
		end else if (n >= 1 && n <= 8) begin
			if (it.cmd == CMD_PUSH) begin
				// refused when the bytes do not fit
				if (n <= CAPACITY - fill) begin
					for (int k = 0; k < n; k++) begin
						sh = it.little_endian ? 8 * k : 8 * (n - 1 - k);
						shadow_bytes[shadow_wr] = it.push_value[sh +: 8];
						shadow_wr = (shadow_wr + 1) % SLOTS;
					end
					r.ok = 1'b1;
				end
			end else if (n <= fill) begin
				// pop or peek: gather bytes from the read pointer on
				v = '0;
				p = shadow_rd;
				for (int k = 0; k < n; k++) begin
					if (it.little_endian)
						v |= 64'(shadow_bytes[p]) << (8 * k);
					else
						v = (v << 8) | 64'(shadow_bytes[p]);
					p = (p + 1) % SLOTS;
				end
				if (it.cmd == CMD_POP)
					shadow_rd = (shadow_rd + n) % SLOTS;
				r.read_value = v;
				r.ok = 1'b1;
			end
		end
		r.fill_level = FILL_W'(shadow_fill());
		return r;
	endfunction

	// Send one item; called right after a rising edge
	task automatic send_item(input in_item_t it);
		if (gaps_enabled && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1'b1;
		cmd_item <= it;
		do @(posedge clk); while (busy);
		pending_results.push_back(fifo_apply(it));
	endtask

	task automatic send_cmd(input cmd_e c, input int unsigned n, input bit le,
		input logic [63:0] val);
		in_item_t it;
		it.cmd = c;
		it.byte_count = 4'(n);
		it.little_endian = le;
		it.push_value = val;
		send_item(it);
	endtask

	// Let the unit go idle and all results arrive
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.read_value !== want.read_value) begin
					$display("%0t: read_value expected %h actual %h", $time,
						want.read_value, result.read_value);
					mismatch_count++;
				end
				if (result.ok !== want.ok) begin
					$display("%0t: ok expected %b actual %b", $time, want.ok, result.ok);
					mismatch_count++;
				end
				if (result.fill_level !== want.fill_level) begin
					$display("%0t: fill_level expected %0d actual %0d", $time,
						want.fill_level, result.fill_level);
					mismatch_count++;
				end
			end
		end
	end

	// Underflow, bad byte counts, both byte orders, clear
	task automatic test_directed();
		send_cmd(CMD_POP, 1, 1'b0, 64'h0);
		send_cmd(CMD_PEEK, 8, 1'b1, 64'h0);
		send_cmd(CMD_PUSH, 0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(CMD_PUSH, 9, 1'b1, 64'h1122_3344_5566_7788);
		send_cmd(CMD_PUSH, 15, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(CMD_PUSH, 8, 1'b0, 64'h0123_4567_89AB_CDEF);
		send_cmd(CMD_PEEK, 8, 1'b1, 64'h0);
		send_cmd(CMD_PEEK, 8, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(CMD_POP, 4, 1'b1, 64'h0);
		send_cmd(CMD_POP, 4, 1'b0, 64'h0);
		send_cmd(CMD_PUSH, 1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(CMD_PUSH, 8, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(CMD_PUSH, 8, 1'b0, 64'h0);
		send_cmd(CMD_POP, 9, 1'b0, 64'h0);
		send_cmd(CMD_PEEK, 0, 1'b1, 64'h0);
		send_cmd(CMD_POP, 8, 1'b0, 64'h0);
		send_cmd(CMD_PEEK, 1, 1'b0, 64'h0);
		send_cmd(CMD_POP, 1, 1'b1, 64'h0);
		send_cmd(CMD_POP, 8, 1'b1, 64'h0);
		send_cmd(CMD_CLEAR, 15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(CMD_PUSH, 3, 1'b1, 64'hA5A5_A5A5_00C0_FFEE);
		send_cmd(CMD_CLEAR, 0, 1'b0, 64'h0);
		send_cmd(CMD_PEEK, 1, 1'b0, 64'h0);
	endtask

	// Fill to capacity, overflow, then drain to empty and underflow
	task automatic test_fill_to_capacity();
		while (shadow_fill() + 8 <= CAPACITY)
			send_cmd(CMD_PUSH, 8, 1'($urandom), {$urandom, $urandom});
		send_cmd(CMD_PUSH, CAPACITY - shadow_fill(), 1'($urandom), {$urandom, $urandom});
		send_cmd(CMD_PUSH, 1, 1'b0, {$urandom, $urandom});
		send_cmd(CMD_PUSH, 8, 1'b1, {$urandom, $urandom});
		send_cmd(CMD_PEEK, 8, 1'($urandom), 64'h0);
		while (shadow_fill() >= 8)
			send_cmd(CMD_POP, 8, 1'($urandom), 64'h0);
		send_cmd(CMD_POP, 8, 1'b0, 64'h0);
		while (shadow_fill() > 0)
			send_cmd(CMD_POP, 1, 1'($urandom), 64'h0);
		send_cmd(CMD_POP, 1, 1'b1, 64'h0);
	endtask

	// Random commands with the given weights; a few carry a bad byte count
	task automatic test_random_mix(input int unsigned count, input int unsigned push_w,
		input int unsigned pop_w, input int unsigned peek_w, input int unsigned clear_w);
		in_item_t    it;
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, push_w + pop_w + peek_w + clear_w - 1);
			if (pick < push_w)
				it.cmd = CMD_PUSH;
			else if (pick < push_w + pop_w)
				it.cmd = CMD_POP;
			else if (pick < push_w + pop_w + peek_w)
				it.cmd = CMD_PEEK;
			else
				it.cmd = CMD_CLEAR;
			if ($urandom_range(0, 99) < 6)
				it.byte_count = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
			else
				it.byte_count = 4'($urandom_range(1, 8));
			it.little_endian = 1'($urandom);
			case ($urandom_range(0, 9))
				0: it.push_value = '0;
				1: it.push_value = '1;
				default: it.push_value = {$urandom, $urandom};
			endcase
			send_item(it);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd_item = '0;
		shadow_rd = 0;
		shadow_wr = 0;
		mismatch_count = 0;
		gaps_enabled = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_idle();
		test_fill_to_capacity();
		wait_idle();
		test_random_mix(200, 85, 10, 5, 1);
		test_random_mix(200, 10, 75, 15, 1);
		test_random_mix(200, 40, 30, 20, 3);
		test_random_mix(200, 85, 10, 5, 1);
		test_random_mix(160, 10, 75, 15, 1);
		// closing stretch with back-to-back items
		gaps_enabled = 1'b0;
		test_random_mix(200, 45, 30, 20, 2);
		wait_idle();

		if (mismatch_count == 0)
			$display("endian_byte_fifo_unit verification clean");
		else
			$display("endian_byte_fifo_unit verification failed");
		$finish;
	end

endmodule

>>> files.f
hdl/efifo_pkg.sv
hdl/efifo_front.sv
hdl/efifo_queue.sv
hdl/efifo_back.sv
hdl/endian_byte_fifo_unit.sv
test/endian_byte_fifo_unit_test.sv
